// File: rtl/core/pvt_pkg.sv
package pvt_pkg;

    // Field widths of the voice word
    localparam int CMD_W     = 2;
    localparam int PRIO_W    = 16;
    localparam int HANDLE_W  = 16;
    localparam int MASK_W    = 16;
    localparam int OUT_CNT_W = 5;
    localparam int ENTRY_W   = PRIO_W + HANDLE_W;

    // Command codes of the input word
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SWEEP  = 2'd2;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_CLEAR,
        OP_DOWN_START,
        OP_UP_START,
        OP_SWEEP_START,
        OP_DOWN_STEP,
        OP_UP_STEP,
        OP_SWEEP_STEP,
        OP_FINAL
    } dp_op_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_DOWN,
        ST_UP,
        ST_SWEEP,
        ST_FINAL,
        ST_PUSH
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        dp_op_t op;
        logic   push;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             full;
        logic             empty;
        logic             down_fin;
        logic             down_final;
        logic             up_fin;
        logic             up_final;
        logic             sweep_last;
    } dp_stat_t;

endpackage

// File: rtl/core/pvt_ram.sv
module pvt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/pvt_ctrl.sv
module pvt_ctrl
    import pvt_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;

    // State and output-valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Sequence one word through the datapath
    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_IDLE;
        cmd.push   = 1'b0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                case (stat.cmd)
                    CMD_INSERT: begin
                        if (stat.full) begin
                            cmd.op     = OP_UP_START;
                            state_next = ST_UP;
                        end else if (stat.empty) begin
                            state_next = ST_FINAL;
                        end else begin
                            cmd.op     = OP_DOWN_START;
                            state_next = ST_DOWN;
                        end
                    end
                    CMD_CLEAR: begin
                        cmd.op     = OP_CLEAR;
                        state_next = ST_PUSH;
                    end
                    CMD_SWEEP: begin
                        if (stat.empty) begin
                            state_next = ST_PUSH;
                        end else begin
                            cmd.op     = OP_SWEEP_START;
                            state_next = ST_SWEEP;
                        end
                    end
                    default: begin
                        state_next = ST_PUSH;
                    end
                endcase
            end
            ST_DOWN: begin
                cmd.op = OP_DOWN_STEP;
                if (stat.down_fin) begin
                    state_next = ST_PUSH;
                end else if (stat.down_final) begin
                    state_next = ST_FINAL;
                end
            end
            ST_UP: begin
                cmd.op = OP_UP_STEP;
                if (stat.up_fin) begin
                    state_next = ST_PUSH;
                end else if (stat.up_final) begin
                    state_next = ST_FINAL;
                end
            end
            ST_SWEEP: begin
                cmd.op = OP_SWEEP_STEP;
                if (stat.sweep_last) begin
                    state_next = ST_PUSH;
                end
            end
            ST_FINAL: begin
                cmd.op     = OP_FINAL;
                state_next = ST_PUSH;
            end
            ST_PUSH: begin
                if (!out_valid_reg || m_ready) begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the result word until taken
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.push) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    assign m_valid = out_valid_reg;

    a_push_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |=> out_valid_reg)
        else $error("result word not presented after push");

    a_push_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |-> (!out_valid_reg || m_ready))
        else $error("push overwrote a waiting result word");

    a_accept_dispatch: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_DISPATCH))
        else $error("accepted word not dispatched");

endmodule

// File: rtl/core/pvt_datapath.sv
module pvt_datapath
    import pvt_pkg::*;
#(
    parameter int MAX_VOICES = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  dp_cmd_t                    cmd,
    output dp_stat_t                   stat,
    input  logic [CMD_W-1:0]           s_cmd,
    input  logic signed [PRIO_W-1:0]   s_priority_req,
    input  logic [HANDLE_W-1:0]        s_handle,
    input  logic [MASK_W-1:0]          s_active_mask,
    output logic                       m_evicted,
    output logic [HANDLE_W-1:0]        m_evicted_handle,
    output logic                       m_cancel_all,
    output logic [OUT_CNT_W-1:0]       m_removed_count,
    output logic [OUT_CNT_W-1:0]       m_occupancy
);

    localparam int IDX_W = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
    localparam int CNT_W = $clog2(MAX_VOICES + 1);

    // Captured word
    logic [CMD_W-1:0]         cmd_reg, cmd_next;
    logic signed [PRIO_W-1:0] pr_reg, pr_next;
    logic [HANDLE_W-1:0]      hd_reg, hd_next;
    logic [MASK_W-1:0]        mask_reg, mask_next;

    // Walk state
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] cur_reg, cur_next;
    logic [CNT_W-1:0] wr_reg, wr_next;

    // Working result
    logic                 ev_reg, ev_next;
    logic [HANDLE_W-1:0]  evh_reg, evh_next;
    logic                 cancel_reg, cancel_next;
    logic [CNT_W-1:0]     removed_reg, removed_next;

    // Output word
    logic                 m_evicted_reg;
    logic [HANDLE_W-1:0]  m_evicted_handle_reg;
    logic                 m_cancel_all_reg;
    logic [OUT_CNT_W-1:0] m_removed_count_reg;
    logic [OUT_CNT_W-1:0] m_occupancy_reg;

    // Table memory port
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [ENTRY_W-1:0] wdata;
    logic [ENTRY_W-1:0] rdata;

    logic                     full, gt, keep, cur_zero, cur_last, ins_write;
    logic signed [PRIO_W-1:0] rd_prio;
    logic [ENTRY_W-1:0]       new_entry;
    logic [CNT_W-1:0]         cur_ext, count_m1, wr_inc;
    logic [7:0]               cur_pos;
    logic [IDX_W-1:0]         cur_inc, cur_dec;

    pvt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_VOICES)
    ) u_table (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (cur_next),
        .rdata (rdata)
    );

    // Entry compares and index arithmetic
    assign rd_prio   = signed'(rdata[ENTRY_W-1:HANDLE_W]);
    assign new_entry = {pr_reg, hd_reg};
    assign full      = (count_reg == CNT_W'(MAX_VOICES));
    assign gt        = (rd_prio > pr_reg);
    assign cur_ext   = CNT_W'(cur_reg);
    assign cur_pos   = 8'(cur_reg);
    assign count_m1  = count_reg - 1'b1;
    assign cur_zero  = (cur_reg == '0);
    assign cur_last  = (cur_ext == count_m1);
    assign cur_inc   = cur_reg + 1'b1;
    assign cur_dec   = cur_reg - 1'b1;
    assign keep      = (cur_pos >= 8'd16) || mask_reg[cur_pos[3:0]];
    assign wr_inc    = wr_reg + CNT_W'(keep);

    // Status to controller
    assign stat.cmd        = cmd_reg;
    assign stat.full       = full;
    assign stat.empty      = (count_reg == '0);
    assign stat.down_fin   = !gt;
    assign stat.down_final = gt && cur_zero;
    assign stat.up_fin     = !cur_zero && gt;
    assign stat.up_final   = (cur_zero || !gt) && cur_last;
    assign stat.sweep_last = cur_last;

    // Execute one datapath operation
    always_comb begin
        cmd_next     = cmd_reg;
        pr_next      = pr_reg;
        hd_next      = hd_reg;
        mask_next    = mask_reg;
        count_next   = count_reg;
        cur_next     = cur_reg;
        wr_next      = wr_reg;
        ev_next      = ev_reg;
        evh_next     = evh_reg;
        cancel_next  = cancel_reg;
        removed_next = removed_reg;
        we           = 1'b0;
        waddr        = cur_reg;
        wdata        = new_entry;
        ins_write    = 1'b0;
        case (cmd.op)
            OP_LOAD: begin
                cmd_next     = s_cmd;
                pr_next      = s_priority_req;
                hd_next      = s_handle;
                mask_next    = s_active_mask;
                wr_next      = '0;
                ev_next      = 1'b0;
                evh_next     = '0;
                cancel_next  = 1'b0;
                removed_next = '0;
            end
            OP_CLEAR: begin
                cancel_next  = 1'b1;
                removed_next = count_reg;
                count_next   = '0;
            end
            OP_DOWN_START: begin
                cur_next = count_m1[IDX_W-1:0];
            end
            OP_UP_START, OP_SWEEP_START: begin
                cur_next = '0;
                wr_next  = '0;
            end
            OP_DOWN_STEP: begin
                // shift larger entries up by one, drop the new one in behind them
                we    = 1'b1;
                waddr = cur_inc;
                if (gt) begin
                    wdata = rdata;
                    if (cur_zero) begin
                        wr_next = '0;
                    end else begin
                        cur_next = cur_dec;
                    end
                end else begin
                    ins_write = 1'b1;
                end
            end
            OP_UP_STEP: begin
                // evict the front, slide smaller-or-equal entries down
                if (cur_zero) begin
                    ev_next  = 1'b1;
                    evh_next = rdata[HANDLE_W-1:0];
                    if (cur_last) begin
                        wr_next = '0;
                    end else begin
                        cur_next = cur_inc;
                    end
                end else if (!gt) begin
                    we    = 1'b1;
                    waddr = cur_dec;
                    wdata = rdata;
                    if (cur_last) begin
                        wr_next = cur_ext;
                    end else begin
                        cur_next = cur_inc;
                    end
                end else begin
                    we        = 1'b1;
                    waddr     = cur_dec;
                    ins_write = 1'b1;
                end
            end
            OP_SWEEP_STEP: begin
                // compact the kept entries toward the front
                if (keep) begin
                    we    = 1'b1;
                    waddr = wr_reg[IDX_W-1:0];
                    wdata = rdata;
                end
                wr_next = wr_inc;
                if (cur_last) begin
                    count_next   = wr_inc;
                    removed_next = count_reg - wr_inc;
                end else begin
                    cur_next = cur_inc;
                end
            end
            OP_FINAL: begin
                we        = 1'b1;
                waddr     = wr_reg[IDX_W-1:0];
                ins_write = 1'b1;
            end
            default: begin
            end
        endcase
        if (ins_write && !full) begin
            count_next = count_reg + 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        pr_reg      <= pr_next;
        hd_reg      <= hd_next;
        mask_reg    <= mask_next;
        cur_reg     <= cur_next;
        wr_reg      <= wr_next;
        ev_reg      <= ev_next;
        evh_reg     <= evh_next;
        cancel_reg  <= cancel_next;
        removed_reg <= removed_next;
        if (cmd.push) begin
            m_evicted_reg        <= ev_reg;
            m_evicted_handle_reg <= evh_reg;
            m_cancel_all_reg     <= cancel_reg;
            m_removed_count_reg  <= OUT_CNT_W'(removed_reg);
            m_occupancy_reg      <= OUT_CNT_W'(count_reg);
        end
    end

    assign m_evicted        = m_evicted_reg;
    assign m_evicted_handle = m_evicted_handle_reg;
    assign m_cancel_all     = m_cancel_all_reg;
    assign m_removed_count  = m_removed_count_reg;
    assign m_occupancy      = m_occupancy_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_VOICES))
        else $error("voice count above table size");

    a_waddr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        we |-> (int'(waddr) < MAX_VOICES))
        else $error("table write outside the table");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_CLEAR) |=> (count_reg == '0))
        else $error("clear left voices in the table");

endmodule

// File: rtl/core/priority_voice_table.sv
// Channel   Direction  Handshake          Word
// s_        in         s_valid / s_ready  cmd, priority_req, handle, active_mask
// m_        out        m_valid / m_ready  evicted, evicted_handle, cancel_all,
//                                         removed_count, occupancy
//
// One word at a time. Accept, then a dispatch state, then for an insert or a
// sweep into a non-empty table a walk over the table memory at one entry per
// cycle (registered read, one write port), then at most one final write and a
// push state that loads the output register. Reset clears only the voice count,
// the controller state and m_valid; table contents are never read above the
// count. A new word is taken while the previous result still waits on m_ready;
// it stalls before its own result is loaded.
module priority_voice_table
    import pvt_pkg::*;
#(
    parameter int MAX_VOICES = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [CMD_W-1:0]         s_cmd,
    input  logic signed [PRIO_W-1:0] s_priority_req,
    input  logic [HANDLE_W-1:0]      s_handle,
    input  logic [MASK_W-1:0]        s_active_mask,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_evicted,
    output logic [HANDLE_W-1:0]      m_evicted_handle,
    output logic                     m_cancel_all,
    output logic [OUT_CNT_W-1:0]     m_removed_count,
    output logic [OUT_CNT_W-1:0]     m_occupancy
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequencer
    pvt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Table and result datapath
    pvt_datapath #(
        .MAX_VOICES (MAX_VOICES)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .stat             (stat),
        .s_cmd            (s_cmd),
        .s_priority_req   (s_priority_req),
        .s_handle         (s_handle),
        .s_active_mask    (s_active_mask),
        .m_evicted        (m_evicted),
        .m_evicted_handle (m_evicted_handle),
        .m_cancel_all     (m_cancel_all),
        .m_removed_count  (m_removed_count),
        .m_occupancy      (m_occupancy)
    );

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import pvt_pkg::*;

    localparam int MAX_VOICES     = 16;
    localparam int RANDOM_WORDS   = 1250;
    localparam int CALM_WORDS     = 150;
    localparam int LONG_HOLD      = 80;
    localparam int TAIL_CYCLES    = 4 * (MAX_VOICES + 4);
    localparam int WATCHDOG_LIMIT = 1000;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // One word for the input channel, plus a flag to wait for all results first
    typedef struct packed {
        logic                drain;
        logic [CMD_W-1:0]    cmd;
        logic [PRIO_W-1:0]   prio;
        logic [HANDLE_W-1:0] handle;
        logic [MASK_W-1:0]   mask;
    } voice_word_t;

    typedef struct packed {
        logic                 evicted;
        logic [HANDLE_W-1:0]  ev_handle;
        logic                 cancel;
        logic [OUT_CNT_W-1:0] removed;
        logic [OUT_CNT_W-1:0] occ;
    } voice_outcome_t;

    logic                     aclk           = 1'b0;
    logic                     aresetn        = 1'b0;
    logic                     s_valid        = 1'b0;
    logic                     s_ready;
    logic [CMD_W-1:0]         s_cmd          = '0;
    logic signed [PRIO_W-1:0] s_priority_req = '0;
    logic [HANDLE_W-1:0]      s_handle       = '0;
    logic [MASK_W-1:0]        s_active_mask  = '0;
    logic                     m_valid;
    logic                     m_ready        = 1'b0;
    logic                     m_evicted;
    logic [HANDLE_W-1:0]      m_evicted_handle;
    logic                     m_cancel_all;
    logic [OUT_CNT_W-1:0]     m_removed_count;
    logic [OUT_CNT_W-1:0]     m_occupancy;

    priority_voice_table #(
        .MAX_VOICES(MAX_VOICES)
    ) u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_priority_req  (s_priority_req),
        .s_handle        (s_handle),
        .s_active_mask   (s_active_mask),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_evicted       (m_evicted),
        .m_evicted_handle(m_evicted_handle),
        .m_cancel_all    (m_cancel_all),
        .m_removed_count (m_removed_count),
        .m_occupancy     (m_occupancy)
    );

    // Shadow copy of the voice table
    logic signed [PRIO_W-1:0] tbl_prio   [MAX_VOICES];
    logic [HANDLE_W-1:0]      tbl_handle [MAX_VOICES];
    int                       tbl_count = 0;

    voice_word_t    queued_cmds[$];
    voice_outcome_t predicted_outcomes[$];

    logic in_taken = 1'b0;
    logic calm     = 1'b0;
    int   gap_left = 0;
    int   hold_left = 0;
    int   long_holds_done = 0;
    int   results_seen = 0;
    int   stuck_cycles = 0;
    int   mismatches = 0;
    int   n_insert = 0, n_clear = 0, n_sweep = 0, n_unused = 0;
    int   n_evict = 0, peak_occ = 0;

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Apply one word to the shadow table and return the result it should give
    function automatic voice_outcome_t predict_voice(input logic [CMD_W-1:0] cmd,
                                                     input logic [PRIO_W-1:0] prio,
                                                     input logic [HANDLE_W-1:0] handle,
                                                     input logic [MASK_W-1:0] mask);
        voice_outcome_t           r;
        logic signed [PRIO_W-1:0] pr;
        int                       i, pos, wr;
        r = '0;
        pr = $signed(prio);
        case (cmd)
            CMD_INSERT: begin
                // full table: drop the front entry first
                if (tbl_count >= MAX_VOICES) begin
                    r.evicted = 1'b1;
                    r.ev_handle = tbl_handle[0];
                    for (i = 1; i < tbl_count; i++) begin
                        tbl_prio[i-1] = tbl_prio[i];
                        tbl_handle[i-1] = tbl_handle[i];
                    end
                    tbl_count--;
                end
                // new entry goes after all entries of lower or equal priority
                pos = 0;
                while (pos < tbl_count && tbl_prio[pos] <= pr) pos++;
                for (i = tbl_count; i > pos; i--) begin
                    tbl_prio[i] = tbl_prio[i-1];
                    tbl_handle[i] = tbl_handle[i-1];
                end
                tbl_prio[pos] = pr;
                tbl_handle[pos] = handle;
                tbl_count++;
            end
            CMD_CLEAR: begin
                r.cancel = 1'b1;
                r.removed = OUT_CNT_W'(tbl_count);
                tbl_count = 0;
            end
            CMD_SWEEP: begin
                // compact the kept entries; positions past the mask are kept
                wr = 0;
                for (i = 0; i < tbl_count; i++) begin
                    if (i >= MASK_W || mask[i]) begin
                        tbl_prio[wr] = tbl_prio[i];
                        tbl_handle[wr] = tbl_handle[i];
                        wr++;
                    end
                end
                r.removed = OUT_CNT_W'(tbl_count - wr);
                tbl_count = wr;
            end
            default: begin
            end
        endcase
        r.occ = OUT_CNT_W'(tbl_count);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic add_word(input logic [CMD_W-1:0] cmd, input logic [PRIO_W-1:0] prio,
                            input logic [HANDLE_W-1:0] handle,
                            input logic [MASK_W-1:0] mask, input logic drain);
        voice_word_t w;
        w.drain = drain;
        w.cmd = cmd;
        w.prio = prio;
        w.handle = handle;
        w.mask = mask;
        queued_cmds.push_back(w);
    endtask

    // Sample both channels, check results, predict accepted words, watchdog
    always @(posedge aclk) begin
        voice_outcome_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (predicted_outcomes.size() == 0) begin
                    $display("%0t: result with no word pending: evicted %0h handle %0h",
                             $time, m_evicted, m_evicted_handle);
                    $display("    cancel %0h removed %0d occupancy %0d",
                             m_cancel_all, m_removed_count, m_occupancy);
                    mismatches++;
                end else begin
                    want = predicted_outcomes[0];
                    predicted_outcomes.delete(0);
                    check_field("evicted", 32'(want.evicted), 32'(m_evicted));
                    check_field("evicted_handle", 32'(want.ev_handle),
                                32'(m_evicted_handle));
                    check_field("cancel_all", 32'(want.cancel), 32'(m_cancel_all));
                    check_field("removed_count", 32'(want.removed), 32'(m_removed_count));
                    check_field("occupancy", 32'(want.occ), 32'(m_occupancy));
                end
                if (m_evicted === 1'b1) n_evict++;
                if (int'(m_occupancy) > peak_occ) peak_occ = int'(m_occupancy);
                results_seen++;
            end
            if (s_valid && s_ready) begin
                predicted_outcomes.push_back(predict_voice(s_cmd, s_priority_req,
                                                           s_handle, s_active_mask));
                case (s_cmd)
                    CMD_INSERT: n_insert++;
                    CMD_CLEAR:  n_clear++;
                    CMD_SWEEP:  n_sweep++;
                    default:    n_unused++;
                endcase
            end
            in_taken <= s_valid && s_ready;
            if ((s_valid && s_ready) || (m_valid && m_ready)) stuck_cycles = 0;
            else stuck_cycles++;
            if (stuck_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("[priority_voice_table] ERROR");
                $finish;
            end
        end
    end

    // Offer queued words; idle in bursts, hold a drain word until all results are in
    always @(negedge aclk) begin
        logic        nv;
        voice_word_t w;
        nv = s_valid;
        if (aresetn) begin
            if (s_valid && in_taken) nv = 1'b0;
            if (!nv) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (queued_cmds.size() > 0 &&
                             !(queued_cmds[0].drain && predicted_outcomes.size() > 0)) begin
                    if (!calm && $urandom_range(0, 5) == 0) begin
                        gap_left = $urandom_range(0, 15);
                    end else begin
                        w = queued_cmds[0];
                        queued_cmds.delete(0);
                        nv = 1'b1;
                        s_cmd <= w.cmd;
                        s_priority_req <= w.prio;
                        s_handle <= w.handle;
                        s_active_mask <= w.mask;
                    end
                end
            end
            calm <= queued_cmds.size() < CALM_WORDS;
        end
        s_valid <= nv;
    end

    // Drive m_ready: random stall bursts plus two long hold-offs
    always @(negedge aclk) begin
        logic rdy;
        rdy = 1'b1;
        if (!aresetn) begin
            rdy = 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end else if (long_holds_done < 2 && results_seen >= 200 + 600 * long_holds_done) begin
            hold_left = LONG_HOLD - 1;
            long_holds_done++;
            rdy = 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            hold_left = $urandom_range(0, 15);
            rdy = 1'b0;
        end
        m_ready <= rdy;
    end

    initial begin
        int                  made, kind, run, mode, k;
        logic [PRIO_W-1:0]   pr;
        logic [MASK_W-1:0]   mk;
        logic                drain;

        // Directed: empty-table commands, extremes, equal priorities, eviction
        add_word(CMD_CLEAR, 16'h1234, 16'hFFFF, 16'hFFFF, 1'b0);
        add_word(CMD_UNUSED, 16'hFFFF, 16'h0000, 16'h0000, 1'b0);
        add_word(CMD_SWEEP, 16'h0000, 16'h5A5A, 16'h0000, 1'b0);
        add_word(CMD_INSERT, 16'h8000, 16'h0001, 16'hFFFF, 1'b0);
        add_word(CMD_INSERT, 16'h7FFF, 16'hFFFF, 16'h0000, 1'b0);
        add_word(CMD_INSERT, 16'h0000, 16'h0000, 16'hFFFF, 1'b0);
        add_word(CMD_INSERT, 16'h0000, 16'h0002, 16'h0000, 1'b0);
        add_word(CMD_INSERT, 16'hFFFF, 16'h0003, 16'hFFFF, 1'b0);
        add_word(CMD_INSERT, 16'h0001, 16'h0004, 16'h0000, 1'b0);
        add_word(CMD_INSERT, 16'h0000, 16'h0005, 16'hFFFF, 1'b0);
        add_word(CMD_INSERT, 16'h7FFF, 16'h0006, 16'h0000, 1'b0);
        add_word(CMD_INSERT, 16'h8000, 16'h0007, 16'hFFFF, 1'b0);
        add_word(CMD_INSERT, 16'h0064, 16'h0008, 16'h0000, 1'b0);
        add_word(CMD_INSERT, 16'hFF9C, 16'h0009, 16'hFFFF, 1'b0);
        add_word(CMD_INSERT, 16'h0005, 16'h000A, 16'h0000, 1'b0);
        add_word(CMD_INSERT, 16'h0005, 16'h000B, 16'hFFFF, 1'b0);
        add_word(CMD_INSERT, 16'h0005, 16'h000C, 16'h0000, 1'b0);
        add_word(CMD_INSERT, 16'h0007, 16'h000D, 16'hFFFF, 1'b0);
        add_word(CMD_INSERT, 16'hFFFE, 16'h000E, 16'h0000, 1'b0);
        // table is full here: this one evicts the oldest lowest entry
        add_word(CMD_INSERT, 16'h0003, 16'h0011, 16'hFFFF, 1'b0);
        add_word(CMD_SWEEP, 16'hFFFF, 16'h0000, 16'h5555, 1'b0);
        add_word(CMD_SWEEP, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b0);
        add_word(CMD_SWEEP, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0);
        add_word(CMD_INSERT, 16'h0001, 16'h0021, 16'hAAAA, 1'b0);
        add_word(CMD_CLEAR, 16'h8000, 16'h0000, 16'hAAAA, 1'b0);

        // Random: mostly insert runs that fill and overflow the table,
        // with sweeps, clears, the unused command and noise mixed in
        made = 0;
        while (made < RANDOM_WORDS) begin
            kind = $urandom_range(0, 99);
            drain = (made == 0) || ($urandom_range(0, 99) == 0);
            if (kind < 55) begin
                run = $urandom_range(1, 24);
                mode = $urandom_range(0, 3);
                for (k = 0; k < run; k++) begin
                    case (mode)
                        0: pr = PRIO_W'($urandom);
                        1: pr = PRIO_W'($urandom_range(0, 6) - 3);
                        2: begin
                            case ($urandom_range(0, 5))
                                0: pr = 16'h8000;
                                1: pr = 16'h7FFF;
                                2: pr = 16'h0000;
                                3: pr = 16'hFFFF;
                                4: pr = 16'h8001;
                                default: pr = 16'h7FFE;
                            endcase
                        end
                        default: pr = PRIO_W'($urandom_range(0, 63) - 32);
                    endcase
                    add_word(CMD_INSERT, pr, HANDLE_W'($urandom), MASK_W'($urandom),
                             drain && k == 0);
                    made++;
                end
            end else if (kind < 78) begin
                case ($urandom_range(0, 3))
                    0: mk = MASK_W'($urandom);
                    1: mk = MASK_W'($urandom & $urandom);
                    2: mk = MASK_W'($urandom | $urandom);
                    default: mk = MASK_W'($urandom | $urandom | $urandom);
                endcase
                add_word(CMD_SWEEP, PRIO_W'($urandom), HANDLE_W'($urandom), mk, drain);
                made++;
            end else if (kind < 88) begin
                add_word(CMD_CLEAR, PRIO_W'($urandom), HANDLE_W'($urandom),
                         MASK_W'($urandom), drain);
                made++;
            end else if (kind < 93) begin
                add_word(CMD_UNUSED, PRIO_W'($urandom), HANDLE_W'($urandom),
                         MASK_W'($urandom), drain);
                made++;
            end else begin
                add_word(CMD_W'($urandom_range(0, 3)), PRIO_W'($urandom),
                         HANDLE_W'($urandom), MASK_W'($urandom), drain);
                made++;
            end
        end

        // Hold reset, then release it on a falling edge
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Wait for every word to go in and every result to come out
        while (queued_cmds.size() > 0 || s_valid || predicted_outcomes.size() > 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Run covered %0d inserts (%0d evictions), %0d sweeps, %0d clears, %0d unused",
                 n_insert, n_evict, n_sweep, n_clear, n_unused);
        $display("Peak occupancy %0d, %0d results checked, %0d long receiver hold-offs",
                 peak_occ, results_seen, long_holds_done);
        if (mismatches == 0) begin
            $display("[priority_voice_table] OK");
        end else begin
            $display("[priority_voice_table] ERROR");
        end
        $finish;
    end

endmodule
